>>> rtl/uan_pkg.sv
`timescale 1ns / 1ps

package uan_pkg;

  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] PFB_FIRST   = 21'h00FE80;
  localparam logic [20:0] PFB_LAST    = 21'h00FE92;
  localparam int          PFB_COUNT   = 19;

  // base letters for presentation forms FE80..FE92
  localparam logic [15:0] BASE_LETTER [PFB_COUNT] = '{
    16'h0621,
    16'h0622, 16'h0622,
    16'h0623, 16'h0623,
    16'h0624, 16'h0624,
    16'h0625, 16'h0625,
    16'h0626, 16'h0626, 16'h0626, 16'h0626,
    16'h0627, 16'h0627,
    16'h0628, 16'h0628, 16'h0628, 16'h0628
  };

  localparam int QUEUE_DEPTH = 2;

  // one decoded and classified codepoint, handed from front to back
  typedef struct packed {
    logic [20:0] cp;
    logic        last;
    logic        arabic;
    logic        tashkeel;
    logic [15:0] count;
  } cp_rec_t;

  typedef struct packed {
    logic    push;
    cp_rec_t data;
  } q_wr_t;

  typedef struct packed {
    logic    valid;
    cp_rec_t data;
  } q_rd_t;

endpackage

>>> rtl/uan_front.sv
`timescale 1ns / 1ps

module uan_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  logic           q_full,
  output uan_pkg::q_wr_t q_wr
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [20:0]           partial_code;
  logic [1:0]            bytes_left;
  logic                  arabic_seen;
  logic                  tashkeel_seen;
  logic [COUNT_BITS-1:0] chars_seen;

  logic [20:0]           code_next;
  logic [1:0]            left_next;
  logic [20:0]           cp;
  logic                  done;
  logic                  accept;
  logic                  arabic_next;
  logic                  tashkeel_next;
  logic [COUNT_BITS-1:0] count_next;
  logic [20:0]           cont_bits;

  function automatic logic [20:0] to_base(input logic [20:0] c);
    if (c >= uan_pkg::PFB_FIRST && c <= uan_pkg::PFB_LAST)
      return {5'd0, uan_pkg::BASE_LETTER[c[4:0]]};
    return c;
  endfunction

  function automatic logic is_arabic(input logic [20:0] c);
    return (c >= 21'h0600 && c <= 21'h06FF) ||
           (c >= 21'h0750 && c <= 21'h077F) ||
           (c >= 21'h08A0 && c <= 21'h08FF) ||
           (c >= 21'hFB50 && c <= 21'hFDFF) ||
           (c >= 21'hFE70 && c <= 21'hFEFF);
  endfunction

  function automatic logic is_tashkeel(input logic [20:0] c);
    return (c >= 21'h064B && c <= 21'h065F) ||
           (c == 21'h0670) ||
           (c >= 21'h06D6 && c <= 21'h06ED);
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    cont_bits = '0;
    code_next = partial_code;
    left_next = bytes_left;
    if (bytes_left == 2'd0) begin
      priority if (!in_byte[7]) begin
        code_next = {13'd0, in_byte};
        left_next = 2'd0;
      end else if (in_byte[7:5] == 3'b110) begin
        code_next = {10'd0, in_byte[4:0], 6'd0};
        left_next = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        code_next = {5'd0, in_byte[3:0], 12'd0};
        left_next = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        code_next = {in_byte[2:0], 18'd0};
        left_next = 2'd3;
      end else begin
        code_next = uan_pkg::REPLACEMENT;
        left_next = 2'd0;
      end
    end else begin
      unique case (bytes_left)
        2'd3:    cont_bits = {3'd0, in_byte[5:0], 12'd0};
        2'd2:    cont_bits = {9'd0, in_byte[5:0], 6'd0};
        default: cont_bits = {15'd0, in_byte[5:0]};
      endcase
      code_next = partial_code | cont_bits;
      left_next = bytes_left - 2'd1;
    end
  end

  assign done          = (left_next == 2'd0) || in_last;
  assign cp            = to_base(code_next);
  assign arabic_next   = arabic_seen | is_arabic(cp);
  assign tashkeel_next = tashkeel_seen | is_tashkeel(cp);
  assign count_next    = (chars_seen != COUNT_MAX) ? chars_seen + 1'b1 : chars_seen;

  always_comb begin
    q_wr.push          = accept && done;
    q_wr.data.cp       = cp;
    q_wr.data.last     = in_last;
    q_wr.data.arabic   = arabic_next;
    q_wr.data.tashkeel = tashkeel_next;
    q_wr.data.count    = 16'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code  <= '0;
      bytes_left    <= '0;
      arabic_seen   <= 1'b0;
      tashkeel_seen <= 1'b0;
      chars_seen    <= '0;
    end else if (accept) begin
      if (done) begin
        partial_code <= '0;
        bytes_left   <= '0;
        if (in_last) begin
          arabic_seen   <= 1'b0;
          tashkeel_seen <= 1'b0;
          chars_seen    <= '0;
        end else begin
          arabic_seen   <= arabic_next;
          tashkeel_seen <= tashkeel_next;
          chars_seen    <= count_next;
        end
      end else begin
        partial_code <= code_next;
        bytes_left   <= left_next;
      end
    end
  end

endmodule

>>> rtl/uan_queue.sv
`timescale 1ns / 1ps

module uan_queue (
  input  logic           clk,
  input  logic           rst,
  input  uan_pkg::q_wr_t q_wr,
  output logic           q_full,
  output uan_pkg::q_rd_t q_rd,
  input  logic           q_pop
);

  localparam int AW = (uan_pkg::QUEUE_DEPTH > 1) ? $clog2(uan_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(uan_pkg::QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(uan_pkg::QUEUE_DEPTH - 1);

  uan_pkg::cp_rec_t slots [uan_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    head;
  logic [AW-1:0]    tail;
  logic [CW-1:0]    count;
  logic             do_pop;

  assign q_full     = (count == CW'(uan_pkg::QUEUE_DEPTH));
  assign q_rd.valid = (count != '0);
  assign q_rd.data  = slots[head];
  assign do_pop     = q_pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (q_wr.push)
      slots[tail] <= q_wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (q_wr.push)
        tail <= (tail == LAST_SLOT) ? '0 : tail + 1'b1;
      if (do_pop)
        head <= (head == LAST_SLOT) ? '0 : head + 1'b1;
      if (q_wr.push && !do_pop)
        count <= count + 1'b1;
      else if (do_pop && !q_wr.push)
        count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/uan_back.sv
`timescale 1ns / 1ps

module uan_back (
  input  logic           clk,
  input  logic           rst,
  input  uan_pkg::q_rd_t q_rd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic [20:0]    code_point,
  output logic           char_end,
  output logic           string_end,
  output logic           has_arabic,
  output logic           has_tashkeel,
  output logic [15:0]    char_count
);

  uan_pkg::cp_rec_t cur;
  logic             cur_valid;
  logic [1:0]       idx;

  logic [1:0] len_m1;
  logic [1:0] rem;
  logic       final_byte;
  logic       out_load;
  logic [7:0] byte_val;
  logic [5:0] chunk;

  // encoded length minus one
  always_comb begin
    priority if (cur.cp < 21'h80)    len_m1 = 2'd0;
    else if (cur.cp < 21'h800)       len_m1 = 2'd1;
    else if (cur.cp < 21'h10000)     len_m1 = 2'd2;
    else                             len_m1 = 2'd3;
  end

  assign rem        = len_m1 - idx;
  assign final_byte = (idx == len_m1);

  always_comb begin
    unique case (rem)
      2'd0: chunk = cur.cp[5:0];
      2'd1: chunk = cur.cp[11:6];
      2'd2: chunk = cur.cp[17:12];
      default: chunk = {3'd0, cur.cp[20:18]};
    endcase
    if (idx == 2'd0) begin
      unique case (len_m1)
        2'd0: byte_val = cur.cp[7:0];
        2'd1: byte_val = {3'b110, cur.cp[10:6]};
        2'd2: byte_val = {4'b1110, cur.cp[15:12]};
        default: byte_val = {5'b11110, cur.cp[20:18]};
      endcase
    end else begin
      byte_val = {2'b10, chunk};
    end
  end

  assign out_load = cur_valid && (!out_valid || !out_stall);
  assign q_pop    = q_rd.valid && (!cur_valid || (out_load && final_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (out_load) begin
        if (final_byte) begin
          cur_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (out_load)
        out_valid <= 1'b1;
      else if (!out_stall)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop)
      cur <= q_rd.data;
    if (out_load) begin
      out_byte     <= byte_val;
      code_point   <= cur.cp;
      char_end     <= final_byte;
      string_end   <= final_byte && cur.last;
      has_arabic   <= cur.arabic;
      has_tashkeel <= cur.tashkeel;
      char_count   <= cur.count;
    end
  end

endmodule

>>> rtl/utf8_arabic_normalizer.sv
`timescale 1ns / 1ps

// utf8 decoder, arabic presentation-form normalizer and re-encoder
// input channel: in_valid / in_stall carry one string byte per beat, in_last
//   marks the final byte of a string
// output channel: out_valid / out_stall carry one byte of the re-encoded text
//   per beat with its codepoint, char_end and string_end; has_arabic,
//   has_tashkeel and char_count are the string summary on the string_end beat
// the front decodes and classifies at one input byte per cycle while the queue has
// room and pushes each finished codepoint into a two-entry queue; the back emits 1
// to 4 bytes per codepoint at one byte per cycle while the output is not stalled
// a completed codepoint passes through a queue slot, the back's current register and
//   the output registers before its first output beat
// throughput: one input byte per cycle while the output side keeps up; a
//   codepoint occupies the back until all its encoded bytes are out, so
//   in_stall rises once the queue fills
// reset clears the partial sequence, string flags, count, queue and output
// a stalled output beat holds; the back and then the queue back up into
//   in_stall

module utf8_arabic_normalizer #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [20:0] code_point,
  output logic        char_end,
  output logic        string_end,
  output logic        has_arabic,
  output logic        has_tashkeel,
  output logic [15:0] char_count
);

  uan_pkg::q_wr_t q_wr;
  uan_pkg::q_rd_t q_rd;
  logic           q_full;
  logic           q_pop;

  uan_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  uan_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  uan_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_rd         (q_rd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .code_point   (code_point),
    .char_end     (char_end),
    .string_end   (string_end),
    .has_arabic   (has_arabic),
    .has_tashkeel (has_tashkeel),
    .char_count   (char_count)
  );

endmodule

>>> test/tb_utf8_arabic_normalizer.sv
`timescale 1ns / 1ps

module tb_utf8_arabic_normalizer;

  localparam logic [20:0] UCS_REPLACEMENT = 21'h00FFFD;
  localparam logic [15:0] CHARS_MAX = 16'hFFFF;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic [7:0] data;
    logic       last_flag;
  } raw_beat_t;

  typedef struct {
    logic [7:0]  enc_byte;
    logic [20:0] cpoint;
    logic        chr_end;
    logic        str_end;
    logic        arabic;
    logic        tashkeel;
    logic [15:0] count;
  } norm_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [20:0] code_point;
  logic        char_end;
  logic        string_end;
  logic        has_arabic;
  logic        has_tashkeel;
  logic [15:0] char_count;

  raw_beat_t  text_q[$];
  norm_beat_t norm_q[$];
  raw_beat_t  next_beat;
  norm_beat_t want;

  int send_idle_pct = 8;
  int recv_stall_pct = 59;
  int err_count = 0;
  int bytes_queued = 0;
  int beats_in = 0;
  int hold_left = 0;
  int holds_done = 0;

  // decoder state of the predictor
  logic [20:0] dec_code = '0;
  logic [1:0]  dec_left = '0;
  logic        str_arabic = 1'b0;
  logic        str_tashkeel = 1'b0;
  logic [15:0] str_chars = '0;

  utf8_arabic_normalizer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .code_point  (code_point),
    .char_end    (char_end),
    .string_end  (string_end),
    .has_arabic  (has_arabic),
    .has_tashkeel(has_tashkeel),
    .char_count  (char_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // presentation forms FE80..FE92 fold onto hamza, alef variants, waw, yeh, alef, beh
  function automatic logic [20:0] base_form(input logic [20:0] cp);
    case (cp)
      21'h0FE80:                                  return 21'h000621;
      21'h0FE81, 21'h0FE82:                       return 21'h000622;
      21'h0FE83, 21'h0FE84:                       return 21'h000623;
      21'h0FE85, 21'h0FE86:                       return 21'h000624;
      21'h0FE87, 21'h0FE88:                       return 21'h000625;
      21'h0FE89, 21'h0FE8A, 21'h0FE8B, 21'h0FE8C: return 21'h000626;
      21'h0FE8D, 21'h0FE8E:                       return 21'h000627;
      21'h0FE8F, 21'h0FE90, 21'h0FE91, 21'h0FE92: return 21'h000628;
      default:                                    return cp;
    endcase
  endfunction

  function automatic logic is_arabic(input logic [20:0] cp);
    return (cp >= 21'h0600 && cp <= 21'h06FF) || (cp >= 21'h0750 && cp <= 21'h077F) ||
           (cp >= 21'h08A0 && cp <= 21'h08FF) || (cp >= 21'hFB50 && cp <= 21'hFDFF) ||
           (cp >= 21'hFE70 && cp <= 21'hFEFF);
  endfunction

  function automatic logic is_tashkeel(input logic [20:0] cp);
    return (cp >= 21'h064B && cp <= 21'h065F) || cp == 21'h0670 ||
           (cp >= 21'h06D6 && cp <= 21'h06ED);
  endfunction

  // shortest utf-8 form, lead byte in e[0]
  function automatic int utf8_encode(input logic [20:0] cp, output logic [3:0][7:0] e);
    e = '0;
    if (cp < 21'h80) begin
      e[0] = cp[7:0];
      return 1;
    end
    if (cp < 21'h800) begin
      e[0] = {3'b110, cp[10:6]};
      e[1] = {2'b10, cp[5:0]};
      return 2;
    end
    if (cp < 21'h10000) begin
      e[0] = {4'b1110, cp[15:12]};
      e[1] = {2'b10, cp[11:6]};
      e[2] = {2'b10, cp[5:0]};
      return 3;
    end
    e[0] = {5'b11110, cp[20:18]};
    e[1] = {2'b10, cp[17:12]};
    e[2] = {2'b10, cp[11:6]};
    e[3] = {2'b10, cp[5:0]};
    return 4;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic lst);
    logic [20:0]     cp;
    logic [3:0][7:0] enc;
    norm_beat_t      nb;
    int              n;
    if (dec_left == 2'd0) begin
      if (!b[7]) begin
        dec_code = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        dec_code = {10'd0, b[4:0], 6'd0};
        dec_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        dec_code = {5'd0, b[3:0], 12'd0};
        dec_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        dec_code = {b[2:0], 18'd0};
        dec_left = 2'd3;
      end else begin
        dec_code = UCS_REPLACEMENT;
      end
    end else begin
      // continuation bits land in place, no check of the 10 prefix
      dec_code = dec_code | (21'(b[5:0]) << (6 * (int'(dec_left) - 1)));
      dec_left = dec_left - 2'd1;
    end
    if (dec_left != 2'd0 && !lst) return;
    cp = base_form(dec_code);
    if (is_arabic(cp)) str_arabic = 1'b1;
    if (is_tashkeel(cp)) str_tashkeel = 1'b1;
    if (str_chars != CHARS_MAX) str_chars = str_chars + 16'd1;
    n = utf8_encode(cp, enc);
    for (int k = 0; k < n; k++) begin
      nb.enc_byte = enc[k];
      nb.cpoint   = cp;
      nb.chr_end  = (k == n - 1);
      nb.str_end  = lst && (k == n - 1);
      nb.arabic   = str_arabic;
      nb.tashkeel = str_tashkeel;
      nb.count    = str_chars;
      norm_q.insert(norm_q.size(), nb);
    end
    dec_code = '0;
    dec_left = '0;
    if (lst) begin
      str_arabic   = 1'b0;
      str_tashkeel = 1'b0;
      str_chars    = '0;
    end
  endtask

  task automatic check_field(input string what, input logic [20:0] exp_v,
                             input logic [20:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
      err_count++;
    end
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = text_q.pop_front();
        in_valid <= 1'b1;
        in_byte  <= next_beat.data;
        in_last  <= next_beat.last_flag;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predicts on accepted input beats, checks output beats, drives out_stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte, in_last);
        beats_in++;
      end
      if (out_valid && !out_stall) begin
        if (norm_q.size() == 0) begin
          $display("%0t: unexpected output beat, actual byte %0h cp %0h", $time, out_byte,
                   code_point);
          err_count++;
        end else begin
          want = norm_q.pop_front();
          check_field("out_byte", 21'(want.enc_byte), 21'(out_byte));
          check_field("code_point", want.cpoint, code_point);
          check_field("char_end", 21'(want.chr_end), 21'(char_end));
          check_field("string_end", 21'(want.str_end), 21'(string_end));
          check_field("has_arabic", 21'(want.arabic), 21'(has_arabic));
          check_field("has_tashkeel", 21'(want.tashkeel), 21'(has_tashkeel));
          check_field("char_count", 21'(want.count), 21'(char_count));
        end
      end
      // long back-pressure so the queue fills and in_stall rises
      if (hold_left == 0 && ((holds_done == 0 && beats_in >= 60) ||
                             (holds_done == 1 && beats_in >= 200))) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic add_byte(input logic [7:0] b);
    raw_beat_t rb;
    rb.data = b;
    rb.last_flag = 1'b0;
    text_q.insert(text_q.size(), rb);
    bytes_queued++;
  endtask

  task automatic add_cp(input logic [20:0] cp);
    logic [3:0][7:0] enc;
    int              n;
    n = utf8_encode(cp, enc);
    for (int k = 0; k < n; k++) add_byte(enc[k]);
  endtask

  task automatic end_string();
    text_q[$].last_flag = 1'b1;
  endtask

  task automatic gen_string(input int nchars);
    int          kind;
    int          conts;
    logic [20:0] cp;
    for (int i = 0; i < nchars; i++) begin
      kind = $urandom_range(99);
      if (kind < 22) begin
        add_cp(21'($urandom_range(0, 127)));
      end else if (kind < 34) begin
        add_cp(21'($urandom_range(21'h80, 21'h7FF)));
      end else if (kind < 48) begin
        case ($urandom_range(3))
          0:       cp = 21'($urandom_range(21'h0600, 21'h06FF));
          1:       cp = 21'($urandom_range(21'h064B, 21'h065F));
          2:       cp = 21'($urandom_range(21'h06D6, 21'h06ED));
          default: cp = 21'h0670;
        endcase
        add_cp(cp);
      end else if (kind < 58) begin
        if ($urandom_range(1))
          add_cp(21'($urandom_range(21'hFE80, 21'hFE92)));
        else
          add_cp(21'($urandom_range(21'hFE70, 21'hFEFF)));
      end else if (kind < 65) begin
        case ($urandom_range(2))
          0:       add_cp(21'($urandom_range(21'h0750, 21'h077F)));
          1:       add_cp(21'($urandom_range(21'h08A0, 21'h08FF)));
          default: add_cp(21'($urandom_range(21'hFB50, 21'hFDFF)));
        endcase
      end else if (kind < 73) begin
        add_cp(21'($urandom_range(21'h800, 21'hFFFF)));
      end else if (kind < 80) begin
        add_cp(21'($urandom_range(21'h10000, 21'h1FFFFF)));
      end else if (kind < 86) begin
        // stray continuation or invalid lead
        if ($urandom_range(1))
          add_byte(8'($urandom_range(8'h80, 8'hBF)));
        else
          add_byte(8'($urandom_range(8'hF8, 8'hFF)));
      end else if (kind < 92) begin
        // overlong forms
        cp = 21'($urandom_range(0, 21'h7FF));
        if ($urandom_range(1)) begin
          add_byte({3'b110, 5'(cp[6:6])});
          add_byte({2'b10, cp[5:0]});
        end else begin
          add_byte(8'hE0);
          add_byte({2'b10, 1'b0, cp[10:6]});
          add_byte({2'b10, cp[5:0]});
        end
      end else begin
        add_byte(8'($urandom_range(255)));
      end
    end
    // a lead byte and up to two continuations at the string end, which may cut the sequence off
    if ($urandom_range(9) == 0) begin
      add_byte(8'($urandom_range(8'hC0, 8'hF7)));
      conts = $urandom_range(0, 2);
      for (int k = 0; k < conts; k++) add_byte(8'($urandom_range(8'h80, 8'hBF)));
    end
    end_string();
  endtask

  task automatic gen_random(input int nbytes);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < nbytes) gen_string($urandom_range(1, 8));
  endtask

  // sender waits until everything offered has been taken and every result has come
  task automatic drain();
    @(negedge clk);
    while (text_q.size() != 0 || in_valid || norm_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: ascii extremes
    add_byte(8'h00);
    add_byte(8'h7F);
    end_string();
    // two-byte, presentation forms at both table ends, tashkeel
    add_byte(8'hC2); add_byte(8'h80);
    add_byte(8'hEF); add_byte(8'hBA); add_byte(8'h80);
    add_byte(8'hEF); add_byte(8'hBA); add_byte(8'h92);
    add_byte(8'hD9); add_byte(8'h8B);
    end_string();
    // largest 21-bit value, bad leads, overlong nul
    add_byte(8'hF7); add_byte(8'hBF); add_byte(8'hBF); add_byte(8'hBF);
    add_byte(8'h80);
    add_byte(8'hFF);
    add_byte(8'hF8);
    add_byte(8'hC0); add_byte(8'h80);
    end_string();
    // continuations taken unchecked, then a lead cut off by the string end
    add_byte(8'hE0); add_byte(8'h41); add_byte(8'h41);
    add_byte(8'hE3);
    end_string();
    drain();

    gen_random(45);
    drain();
    gen_random(45);
    drain();

    send_idle_pct = 59;
    recv_stall_pct = 8;
    gen_random(95);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    gen_random(85);
    drain();

    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
